// File: src/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg: shared constants and types for the 4x4 matrix multiplier
// Element geometry, arithmetic widths, operation codes and the command that
// travels from the front end through the queue to the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int MATRIX_DIM  = 4;
  localparam int FRAC_BITS   = 16;
  localparam int ELEM_COUNT  = MATRIX_DIM * MATRIX_DIM;
  localparam int ELEM_W      = $clog2(ELEM_COUNT);
  localparam int K_W         = $clog2(MATRIX_DIM);
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 4;
  localparam int FUNC_W      = 2;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SHIFT_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W       = SHIFT_W + K_W + 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic [ELEM_W-1:0]         elem;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t head;
  } qhead_t;

endpackage

`default_nettype wire

// File: src/matrix_multiply_4x4.sv
// A load is registered in the input stage, then held in a queue slot, and is written to
// its store when the back end pops it. A compute request issues its reads k innermost,
// then row, then column; each result is summed through the read, multiply and accumulate
// registers and saturated into the result register, with the single multiplier doing
// one multiply-accumulate per cycle while the result channel does not stall. Reset clears
// all control state; the matrix stores are not cleared and read as unknown until written.
// ----------------------------------------------------------------------------
// matrix_multiply_4x4: 4x4 fixed-point matrix multiplier
// Loads elements of A and B one transaction at a time and, on request, streams
// the sixteen Q16.16 product elements in column-major order.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_4x4 (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input channel
  input  wire logic                               item_valid,
  output      logic                               item_stall,
  input  wire logic [mm4_pkg::FUNC_W-1:0]         func,
  input  wire logic [mm4_pkg::INDEX_W-1:0]        element_index,
  input  wire logic signed [mm4_pkg::DATA_W-1:0]  element_value,
  // result channel
  output      logic                               result_valid,
  input  wire logic                               result_stall,
  output      logic signed [mm4_pkg::DATA_W-1:0]  result_value,
  output      logic [mm4_pkg::INDEX_W-1:0]        result_index,
  output      logic                               saturated,
  output      logic                               last_result
);

  // Front to queue: classified command, held until the queue has room
  logic            push;
  mm4_pkg::cmd_t   push_cmd;
  logic            q_ready;

  // Queue to back end: head command and its valid flag
  mm4_pkg::qhead_t q_status;
  logic            pop;

  // Input stage: drop unused codes and out-of-range loads here, so the back
  // end only ever sees work it must carry out.
  mm4_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .func          (func),
    .element_index (element_index),
    .element_value (element_value),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_ready       (q_ready)
  );

  // Queue: lets loads pile up behind a running product without stalling the
  // input channel straight away.
  mm4_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (pop),
    .status   (q_status)
  );

  // Back end: a new command is popped only once every read of the current
  // product has been issued, so a following load never disturbs it.
  mm4_back u_back (
    .clk          (clk),
    .rst          (rst),
    .status       (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .result_index (result_index),
    .saturated    (saturated),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire

// File: src/mm4_front.sv
// ----------------------------------------------------------------------------
// mm4_front: input stage
// Accepts input transactions, drops unused codes and out-of-range loads, and
// holds the classified command until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output      logic                           item_stall,
  input  wire logic [mm4_pkg::FUNC_W-1:0]     func,
  input  wire logic [mm4_pkg::INDEX_W-1:0]    element_index,
  input  wire logic signed [mm4_pkg::DATA_W-1:0] element_value,
  output      logic                           push,
  output      mm4_pkg::cmd_t                  push_cmd,
  input  wire logic                           q_ready
);

  logic          f_valid;
  logic          f_valid_next;
  mm4_pkg::cmd_t f_cmd;
  mm4_pkg::cmd_t cmd_in;
  logic          keep;
  logic          accept;

  // Classify the incoming transaction
  always_comb begin
    keep         = 1'b0;
    cmd_in.func  = mm4_pkg::func_t'(func);
    cmd_in.elem  = mm4_pkg::ELEM_W'(element_index);
    cmd_in.value = element_value;
    unique case (func) inside
      mm4_pkg::FUNC_LOAD_A, mm4_pkg::FUNC_LOAD_B: begin
        keep = int'(element_index) < mm4_pkg::ELEM_COUNT;
      end
      mm4_pkg::FUNC_COMPUTE: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_stall = f_valid && !q_ready;
  assign accept     = item_valid && !item_stall;
  assign push       = f_valid;
  assign push_cmd   = f_cmd;

  always_comb begin
    if (accept) begin
      f_valid_next = keep;
    end else if (q_ready) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: src/mm4_queue.sv
// ----------------------------------------------------------------------------
// mm4_queue: command queue
// Short FIFO that decouples the input stage from the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mm4_pkg::cmd_t  push_cmd,
  output      logic           ready,
  input  wire logic           pop,
  output      mm4_pkg::qhead_t status
);

  localparam int PTR_W = (mm4_pkg::QUEUE_DEPTH > 1) ? $clog2(mm4_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mm4_pkg::QUEUE_DEPTH + 1);

  mm4_pkg::cmd_t     slots [mm4_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign ready       = count != CNT_W'(mm4_pkg::QUEUE_DEPTH);
  assign status.valid = count != '0;
  assign status.head  = slots[rd_ptr];
  assign do_push     = push && ready;
  assign do_pop      = pop && status.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mm4_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mm4_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/mm4_back.sv
// ----------------------------------------------------------------------------
// mm4_back: execution back end
// Holds both matrices, runs one multiply-accumulate per cycle unless stalled,
// through a read / multiply / accumulate pipeline and saturates into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mm4_pkg::qhead_t                    status,
  output      logic                               pop,
  output      logic                               result_valid,
  input  wire logic                               result_stall,
  output      logic signed [mm4_pkg::DATA_W-1:0]  result_value,
  output      logic [mm4_pkg::INDEX_W-1:0]        result_index,
  output      logic                               saturated,
  output      logic                               last_result
);

  localparam int K_W     = mm4_pkg::K_W;
  localparam int ELEM_W  = mm4_pkg::ELEM_W;
  localparam int DATA_W  = mm4_pkg::DATA_W;
  localparam int ACC_W   = mm4_pkg::ACC_W;
  localparam int SHIFT_W = mm4_pkg::SHIFT_W;
  localparam int PROD_W  = mm4_pkg::PROD_W;
  localparam int UPPER_W = ACC_W - DATA_W + 1;

  logic signed [DATA_W-1:0] mem_a [mm4_pkg::ELEM_COUNT];
  logic signed [DATA_W-1:0] mem_b [mm4_pkg::ELEM_COUNT];

  logic                     adv;
  logic                     busy;
  logic [K_W-1:0]           k;
  logic [K_W-1:0]           row;
  logic [K_W-1:0]           col;
  logic                     k_last;
  logic                     row_last;
  logic                     col_last;
  logic [ELEM_W-1:0]        addr_a;
  logic [ELEM_W-1:0]        addr_b;
  logic                     wr_a;
  logic                     wr_b;
  logic                     start;

  logic                     s1_v;
  logic                     s1_first;
  logic                     s1_last;
  logic                     s1_final;
  logic [mm4_pkg::INDEX_W-1:0] s1_idx;
  logic signed [DATA_W-1:0] a_rd;
  logic signed [DATA_W-1:0] b_rd;

  logic                     s2_v;
  logic                     s2_first;
  logic                     s2_last;
  logic                     s2_final;
  logic [mm4_pkg::INDEX_W-1:0] s2_idx;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_full;

  logic signed [SHIFT_W-1:0] sh;
  logic signed [ACC_W-1:0]  sh_ext;
  logic signed [ACC_W-1:0]  acc;
  logic                     done_v;
  logic                     done_final;
  logic [mm4_pkg::INDEX_W-1:0] done_idx;
  logic [UPPER_W-1:0]       upper;
  logic                     fits;

  // Whole pipeline moves only when the result register can take a value
  assign adv      = !result_valid || !result_stall;
  assign pop      = adv && !busy && status.valid;

  assign k_last   = k   == K_W'(mm4_pkg::MATRIX_DIM - 1);
  assign row_last = row == K_W'(mm4_pkg::MATRIX_DIM - 1);
  assign col_last = col == K_W'(mm4_pkg::MATRIX_DIM - 1);
  assign addr_a   = ELEM_W'(int'(k) * mm4_pkg::MATRIX_DIM + int'(row));
  assign addr_b   = ELEM_W'(int'(col) * mm4_pkg::MATRIX_DIM + int'(k));

  always_comb begin
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    start = 1'b0;
    unique case (status.head.func)
      mm4_pkg::FUNC_LOAD_A:  wr_a  = pop;
      mm4_pkg::FUNC_LOAD_B:  wr_b  = pop;
      mm4_pkg::FUNC_COMPUTE: start = pop;
      default: begin
        wr_a = 1'b0;
      end
    endcase
  end

  // Issue sequencer: k innermost, then row, then column
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
      row  <= '0;
      col  <= '0;
    end else if (adv) begin
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
        row  <= '0;
        col  <= '0;
      end else if (busy) begin
        k <= k_last ? '0 : k + 1'b1;
        if (k_last) begin
          row <= row_last ? '0 : row + 1'b1;
          if (row_last) begin
            col <= col_last ? '0 : col + 1'b1;
            if (col_last) begin
              busy <= 1'b0;
            end
          end
        end
      end
    end
  end

  // Matrix stores
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[status.head.elem] <= status.head.value;
    end
    if (wr_b) begin
      mem_b[status.head.elem] <= status.head.value;
    end
    if (adv) begin
      a_rd <= mem_a[addr_a];
      b_rd <= mem_b[addr_b];
    end
  end

  assign prod_full = a_rd * b_rd;
  assign sh        = prod[PROD_W-1:mm4_pkg::FRAC_BITS];
  assign sh_ext    = {{(ACC_W - SHIFT_W){sh[SHIFT_W-1]}}, sh};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      done_v <= 1'b0;
    end else if (adv) begin
      s1_v   <= busy;
      s2_v   <= s1_v;
      done_v <= s2_v && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first   <= k == '0;
      s1_last    <= k_last;
      s1_final   <= row_last && col_last;
      s1_idx     <= mm4_pkg::INDEX_W'(int'(col) * mm4_pkg::MATRIX_DIM + int'(row));
      s2_first   <= s1_first;
      s2_last    <= s1_last;
      s2_final   <= s1_final;
      s2_idx     <= s1_idx;
      prod       <= prod_full;
      done_final <= s2_final;
      done_idx   <= s2_idx;
      if (s2_v) begin
        acc <= s2_first ? sh_ext : acc + sh_ext;
      end
    end
  end

  // Sum fits in 32 bits when every bit above the sign position agrees
  assign upper = acc[ACC_W-1:DATA_W-1];
  assign fits  = (&upper) || !(|upper);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= done_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && done_v) begin
      saturated    <= !fits;
      result_index <= done_idx;
      last_result  <= done_final;
      if (fits) begin
        result_value <= acc[DATA_W-1:0];
      end else if (acc[ACC_W-1]) begin
        result_value <= {1'b1, {(DATA_W - 1){1'b0}}};
      end else begin
        result_value <= {1'b0, {(DATA_W - 1){1'b1}}};
      end
    end
  end

endmodule

`default_nettype wire

// File: src/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker: port-level checks for the matrix multiplier
// Watches the result channel for handshake, framing and saturation slips.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               result_valid,
  input wire logic                               result_stall,
  input wire logic signed [mm4_pkg::DATA_W-1:0]  result_value,
  input wire logic [mm4_pkg::INDEX_W-1:0]        result_index,
  input wire logic                               saturated,
  input wire logic                               last_result
);

  // Hold a stalled result transaction unchanged
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(result_value) && $stable(result_index))
    else $error("stalled result transaction changed");

  // Mark only the final product element as last
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |->
      result_index == mm4_pkg::INDEX_W'(mm4_pkg::ELEM_COUNT - 1))
    else $error("last result flag on wrong element");

  // A clipped element carries one of the two range limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      result_value == 32'sh7fffffff || result_value == 32'sh80000000)
    else $error("saturated flag without a limit value");

  // Drop any pending result on reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind matrix_multiply_4x4 mm4_checker u_mm4_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_value (result_value),
  .result_index (result_index),
  .saturated    (saturated),
  .last_result  (last_result)
);

`default_nettype wire
